>>> rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    // default geometry
    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_READ_POS   = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    // request payload
    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [31:0] value;
        logic        [10:0] position;
    } t_req;

    // response payload
    typedef struct packed {
        logic               ok;
        logic signed [31:0] read_value;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               ends_valid;
        logic        [10:0] count;
        logic               is_empty;
        logic               is_full;
    } t_rsp;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    // where the memory read data goes
    typedef enum logic [1:0] {
        DST_NONE,
        DST_READ,
        DST_FRONT,
        DST_BACK
    } t_rd_dst;

endpackage

`default_nettype wire

>>> rtl/circular_deque_core.sv
`default_nettype none

// Double-ended queue over a ring memory of DEPTH entries of DATA_WIDTH bits.
// Each request carries one command (push front/back, pop front/back, read by
// 1-based position from the front, clear) and yields exactly one response with
// the ok flag, the read value, the front and back values, the element count
// and the empty/full flags as they stand after the command. A push to a full
// deque, a pop on an empty one and a read outside 1..count are refused with ok
// low and no change. Front and back elements are kept in registers; the ring
// memory has one write port and one registered read port. An accepted request
// is captured and executed in the EXEC state; a read or a pop that leaves
// elements behind then passes through RDWAIT for the memory read, and the
// response register is loaded from DONE once the output is free. The block
// holds one request at a time: a new request is taken as soon as the
// previous response is in the output register; a stalled response consumer
// holds the block. The memory needs no clearing after reset.
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > 11) ? CW : 11;
    localparam int SW  = ((AW > 11) ? AW : 11) + 1;

    // ring pointer steps
    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    t_state                         r_state, n_state;
    t_req                           r_req;
    logic [AW-1:0]                  r_head, n_head;
    logic [AW-1:0]                  r_tail, n_tail;
    logic [CW-1:0]                  r_count, n_count;
    logic signed [DATA_WIDTH-1:0]   r_front, n_front;
    logic signed [DATA_WIDTH-1:0]   r_back, n_back;
    logic signed [DATA_WIDTH-1:0]   r_read;
    logic                           r_ok, n_ok;
    t_rd_dst                        r_dst, n_dst;
    t_rsp                           r_out;
    logic                           r_out_valid;

    logic                           accept;
    logic                           exec_en;
    logic                           rdwait_en;
    logic                           load_out;
    logic                           out_free;

    logic signed [DATA_WIDTH-1:0]   push_data;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [DATA_WIDTH-1:0]          rd_data;
    logic [SW-1:0]                  pos_sum;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  count_ext;

    // ring memory
    cdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (push_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || i_rsp_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = (n_dst == DST_NONE) ? ST_DONE : ST_RDWAIT;
            end
            ST_RDWAIT: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state decoded controls
    always_comb begin
        o_req_ready = 1'b0;
        exec_en     = 1'b0;
        rdwait_en   = 1'b0;
        load_out    = 1'b0;
        case (r_state)
            ST_IDLE:   o_req_ready = 1'b1;
            ST_EXEC:   exec_en     = 1'b1;
            ST_RDWAIT: rdwait_en   = 1'b1;
            ST_DONE:   load_out    = out_free;
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign accept = i_req_valid && o_req_ready;

    // command execution
    always_comb begin
        push_data = DATA_WIDTH'(r_req.value);
        pos_ext   = PW'(r_req.position);
        count_ext = PW'(r_count);
        pos_sum   = SW'(r_head) + SW'(r_req.position) - SW'(1);
        if (pos_sum >= SW'(DEPTH)) begin
            pos_sum = pos_sum - SW'(DEPTH);
        end

        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_front = r_front;
        n_back  = r_back;
        n_ok    = 1'b0;
        n_dst   = DST_NONE;
        wr_en   = 1'b0;
        wr_addr = r_head;
        rd_en   = 1'b0;
        rd_addr = AW'(pos_sum);

        case (r_req.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (r_count != CW'(DEPTH)) begin
                    n_ok    = 1'b1;
                    wr_en   = exec_en;
                    n_count = r_count + CW'(1);
                    if (r_count == '0) begin
                        n_tail  = r_head;
                        wr_addr = r_head;
                        n_front = push_data;
                        n_back  = push_data;
                    end else if (r_req.cmd == CMD_PUSH_FRONT) begin
                        n_head  = ptr_prev(r_head);
                        wr_addr = n_head;
                        n_front = push_data;
                    end else begin
                        n_tail  = ptr_next(r_tail);
                        wr_addr = n_tail;
                        n_back  = push_data;
                    end
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (r_count != '0) begin
                    n_ok    = 1'b1;
                    n_count = r_count - CW'(1);
                    if (r_count != CW'(1)) begin
                        rd_en = exec_en;
                        if (r_req.cmd == CMD_POP_FRONT) begin
                            n_head  = ptr_next(r_head);
                            rd_addr = n_head;
                            n_dst   = DST_FRONT;
                        end else begin
                            n_tail  = ptr_prev(r_tail);
                            rd_addr = n_tail;
                            n_dst   = DST_BACK;
                        end
                    end
                end
            end
            CMD_READ_POS: begin
                if (pos_ext != '0 && pos_ext <= count_ext) begin
                    n_ok  = 1'b1;
                    rd_en = exec_en;
                    n_dst = DST_READ;
                end
            end
            CMD_CLEAR: begin
                n_ok    = 1'b1;
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_en) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and cached ends
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (exec_en) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_ok    <= n_ok;
            r_dst   <= n_dst;
            r_read  <= '0;
        end
        if (rdwait_en) begin
            case (r_dst)
                DST_READ:  r_read  <= rd_data;
                DST_FRONT: r_front <= rd_data;
                DST_BACK:  r_back  <= rd_data;
                default:   r_read  <= r_read;
            endcase
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.ok          <= r_ok;
            r_out.read_value  <= 32'(r_read);
            r_out.front_value <= (r_count != '0) ? 32'(r_front) : '0;
            r_out.back_value  <= (r_count != '0) ? 32'(r_back) : '0;
            r_out.ends_valid  <= (r_count != '0);
            r_out.count       <= 11'(r_count);
            r_out.is_empty    <= (r_count == '0);
            r_out.is_full     <= (r_count == CW'(DEPTH));
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

>>> rtl/cdq_ram.sv
`default_nettype none

module cdq_ram
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0] i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [AW-1:0]         i_rd_addr,
    output logic      [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top
    import cdq_pkg::*;
();

    localparam int DEPTH    = DEPTH_DEF;
    localparam int EXP_SLOTS = 64;
    localparam int ROW_SLOTS = 32;

    // codes the block must ignore
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_rsp_ready = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    circular_deque_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the deque
    logic [31:0] shadow_ring [DEPTH];
    int unsigned head_idx = 0;
    int unsigned tail_idx = 0;
    int unsigned fill_cnt = 0;

    // outstanding responses, oldest first
    t_rsp exp_ring [EXP_SLOTS];
    int   exp_wr       = 0;
    int   exp_rd       = 0;
    int   mismatch_cnt = 0;
    int   rsp_idx      = 0;
    bit   quiet        = 1'b0;

    // directed rows: typed response where obvious, else from the shadow deque
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    t_row directed_rows [ROW_SLOTS];
    int   row_cnt = 0;

    // apply one command to the shadow deque and return the response it gives
    function automatic t_rsp apply_deque_cmd(t_req r);
        t_rsp res;
        res = '0;
        case (r.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (fill_cnt < DEPTH) begin
                    if (fill_cnt == 0) begin
                        tail_idx = head_idx;
                        shadow_ring[head_idx] = r.value;
                    end else if (r.cmd == CMD_PUSH_FRONT) begin
                        head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                        shadow_ring[head_idx] = r.value;
                    end else begin
                        tail_idx = (tail_idx + 1) % DEPTH;
                        shadow_ring[tail_idx] = r.value;
                    end
                    fill_cnt++;
                    res.ok = 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (fill_cnt != 0) begin
                    // last element leaves both pointers where they are
                    if (fill_cnt > 1) begin
                        if (r.cmd == CMD_POP_FRONT)
                            head_idx = (head_idx + 1) % DEPTH;
                        else
                            tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                    end
                    fill_cnt--;
                    res.ok = 1'b1;
                end
            end
            CMD_READ_POS: begin
                if (r.position >= 1 && r.position <= fill_cnt) begin
                    res.read_value = shadow_ring[(head_idx + r.position - 1) % DEPTH];
                    res.ok = 1'b1;
                end
            end
            CMD_CLEAR: begin
                head_idx = 0;
                tail_idx = 0;
                fill_cnt = 0;
                res.ok   = 1'b1;
            end
            default: begin
            end
        endcase
        if (fill_cnt != 0) begin
            res.front_value = shadow_ring[head_idx];
            res.back_value  = shadow_ring[tail_idx];
            res.ends_valid  = 1'b1;
        end
        res.count    = fill_cnt[10:0];
        res.is_empty = (fill_cnt == 0);
        res.is_full  = (fill_cnt == DEPTH);
        return res;
    endfunction

    function automatic t_rsp mk_rsp(logic ok, logic [31:0] rd, logic [31:0] fr,
                                    logic [31:0] bk, int unsigned cnt);
        t_rsp res;
        res.ok          = ok;
        res.read_value  = rd;
        res.front_value = fr;
        res.back_value  = bk;
        res.ends_valid  = (cnt != 0);
        res.count       = cnt[10:0];
        res.is_empty    = (cnt == 0);
        res.is_full     = (cnt == DEPTH);
        return res;
    endfunction

    task automatic add_row(logic [2:0] cmd, logic [31:0] val, logic [10:0] pos,
                           bit typed, t_rsp rsp);
        t_row row;
        row.req.cmd      = cmd;
        row.req.value    = val;
        row.req.position = pos;
        row.typed        = typed;
        row.rsp          = rsp;
        directed_rows[row_cnt] = row;
        row_cnt++;
    endtask

    // read position: mostly in range, with both edges and one past the end
    function automatic logic [10:0] pick_read_pos();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (fill_cnt == 0 || roll < 10)
            return 11'($urandom_range(0, 2047));
        else if (roll < 20)
            return 11'd1;
        else if (roll < 35)
            return fill_cnt[10:0];
        else if (roll < 42)
            return fill_cnt[10:0] + 11'd1;
        return 11'($urandom_range(1, fill_cnt));
    endfunction

    // push-heavy mix that drives the deque to full and keeps pushing there
    function automatic t_req draw_fill_req();
        t_req r;
        int unsigned roll;
        r.value    = $urandom;
        r.position = 11'($urandom_range(0, 2047));
        roll       = $urandom_range(0, 99);
        if (roll < 48)
            r.cmd = CMD_PUSH_FRONT;
        else if (roll < 96)
            r.cmd = CMD_PUSH_BACK;
        else if (roll < 98) begin
            r.cmd      = CMD_READ_POS;
            r.position = pick_read_pos();
        end else if (roll < 99)
            r.cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        else
            r.cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
        return r;
    endfunction

    // balanced mix that stays near empty
    function automatic t_req draw_mixed_req();
        t_req r;
        int unsigned roll;
        r.value    = $urandom;
        r.position = 11'($urandom_range(0, 2047));
        roll       = $urandom_range(0, 99);
        if (roll < 18)
            r.cmd = CMD_PUSH_FRONT;
        else if (roll < 36)
            r.cmd = CMD_PUSH_BACK;
        else if (roll < 52)
            r.cmd = CMD_POP_FRONT;
        else if (roll < 68)
            r.cmd = CMD_POP_BACK;
        else if (roll < 90) begin
            r.cmd      = CMD_READ_POS;
            r.position = pick_read_pos();
        end else if (roll < 95)
            r.cmd = CMD_CLEAR;
        else
            r.cmd = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
        return r;
    endfunction

    // drive one request, wait for it to be taken, then queue its response
    task automatic send_req(t_req r, bit typed, t_rsp typed_rsp);
        int   gap;
        t_rsp pred;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < 9)
            gap++;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        pred = apply_deque_cmd(r);
        exp_ring[exp_wr % EXP_SLOTS] = typed ? typed_rsp : pred;
        exp_wr++;
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("response %0d: %s expected %h got %h", rsp_idx, fname, want, got);
        end
    endtask

    // response checker
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (exp_wr == exp_rd) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("response %0d arrived with nothing outstanding", rsp_idx);
            end else begin
                want = exp_ring[exp_rd % EXP_SLOTS];
                exp_rd++;
                check_field("ok", 32'(want.ok), 32'(o_rsp.ok));
                check_field("read_value", want.read_value, o_rsp.read_value);
                check_field("front_value", want.front_value, o_rsp.front_value);
                check_field("back_value", want.back_value, o_rsp.back_value);
                check_field("ends_valid", 32'(want.ends_valid), 32'(o_rsp.ends_valid));
                check_field("count", 32'(want.count), 32'(o_rsp.count));
                check_field("is_empty", 32'(want.is_empty), 32'(o_rsp.is_empty));
                check_field("is_full", 32'(want.is_full), 32'(o_rsp.is_full));
            end
            rsp_idx++;
        end
    end

    // response back-pressure
    always @(posedge i_clk) begin
        i_rsp_ready <= quiet || ($urandom_range(0, 99) >= 9);
    end

    // stimulus
    initial begin
        int   n;
        int   past_full;
        t_rsp refused;
        refused = mk_rsp(1'b0, '0, '0, '0, 0);

        // empty deque: pops, reads and unknown codes are all refused
        add_row(CMD_POP_FRONT,  32'h1234_5678, 11'd0,    1'b1, refused);
        add_row(CMD_POP_BACK,   32'h0,         11'd1,    1'b1, refused);
        add_row(CMD_READ_POS,   32'h0,         11'd1,    1'b1, refused);
        add_row(CMD_READ_POS,   32'h0,         11'd0,    1'b1, refused);
        add_row(CMD_RSVD_6,     32'hFFFF_FFFF, 11'd2047, 1'b1, refused);
        add_row(CMD_RSVD_7,     32'h0,         11'd0,    1'b1, refused);
        add_row(CMD_CLEAR,      32'h0,         11'd0,    1'b1, mk_rsp(1'b1, '0, '0, '0, 0));
        // extremes of the value field
        add_row(CMD_PUSH_BACK,  32'h8000_0000, 11'd0,    1'b1,
                mk_rsp(1'b1, '0, 32'h8000_0000, 32'h8000_0000, 1));
        add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 11'd2047, 1'b1,
                mk_rsp(1'b1, '0, 32'h7FFF_FFFF, 32'h8000_0000, 2));
        add_row(CMD_PUSH_BACK,  32'hFFFF_FFFF, 11'd0,    1'b0, '0);
        add_row(CMD_PUSH_FRONT, 32'h0,         11'd0,    1'b0, '0);
        // reads at both ends, one past the end, zero, all ones
        add_row(CMD_READ_POS,   32'h0,         11'd1,    1'b0, '0);
        add_row(CMD_READ_POS,   32'h0,         11'd4,    1'b0, '0);
        add_row(CMD_READ_POS,   32'h0,         11'd5,    1'b0, '0);
        add_row(CMD_READ_POS,   32'h0,         11'd0,    1'b0, '0);
        add_row(CMD_READ_POS,   32'hFFFF_FFFF, 11'd2047, 1'b0, '0);
        add_row(CMD_RSVD_6,     32'h5555_5555, 11'd3,    1'b0, '0);
        // pop down to empty, the last pop leaves the pointers in place
        add_row(CMD_POP_BACK,   32'h0,         11'd0,    1'b0, '0);
        add_row(CMD_POP_FRONT,  32'h0,         11'd0,    1'b0, '0);
        add_row(CMD_POP_FRONT,  32'h0,         11'd0,    1'b0, '0);
        add_row(CMD_POP_BACK,   32'h0,         11'd0,    1'b0, '0);
        add_row(CMD_POP_FRONT,  32'h0,         11'd0,    1'b1, refused);
        // push into a deque emptied by pops
        add_row(CMD_PUSH_FRONT, 32'hDEAD_BEEF, 11'd0,    1'b0, '0);
        add_row(CMD_READ_POS,   32'h0,         11'd1,    1'b0, '0);
        add_row(CMD_CLEAR,      32'h0,         11'd0,    1'b1, mk_rsp(1'b1, '0, '0, '0, 0));

        // synchronous reset, then release
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < row_cnt; k++)
            send_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].rsp);

        // fill to the top, with a stretch of full throughput in the middle
        n         = 0;
        past_full = 0;
        while (past_full < 16) begin
            if (fill_cnt == DEPTH)
                past_full++;
            quiet = (n >= 300 && n < 600);
            send_req(draw_fill_req(), 1'b0, '0);
            n++;
        end
        quiet = 1'b0;

        // mixed traffic with every command, starting from the filled deque
        repeat (40)
            send_req(draw_mixed_req(), 1'b0, '0);

        i_req_valid <= 1'b0;

        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_core.sv
verif/tb_top.sv
